/* sv/btd_pkg.sv */
// btd_pkg: shared types and constants for the beam trip detector.
// Used by btd_regs, btd_mul and beam_trip_detector; no dependencies.
`default_nettype none

package btd_pkg;

  localparam int ADDR_W = 4;   // four 32-bit registers at 4*i
  localparam int DATA_W = 32;
  localparam int CNT_W  = 16;
  localparam int SUM_W  = 24;
  localparam int AVG_W  = 8;   // user must keep AVG_COUNT at most 255; the block does not enforce it
  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;
  localparam int BAND_W = 40;  // m^2 * N * S fits in 4+4+8+24 bits

  localparam logic [15:0] MIN_RATE_RST       = 16'd10;
  localparam logic [15:0] COUNT_FLOOR_RST    = 16'd2;
  localparam logic [15:0] SKIP_LENGTH_RST    = 16'd201;
  localparam logic [3:0]  SIGMA_MULTIPLE_RST = 4'd4;

  typedef enum logic [1:0] {
    REG_MIN_RATE       = 2'd0,
    REG_COUNT_FLOOR    = 2'd1,
    REG_SKIP_LENGTH    = 2'd2,
    REG_SIGMA_MULTIPLE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] min_rate;
    logic [15:0] count_floor;
    logic [15:0] skip_length;
    logic [3:0]  sigma_multiple;
  } cfg_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_BAND = 2'd1,
    EV_HIGH = 2'd2
  } ev_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MRN,   // min_rate * N
    ST_MM,    // m * m
    ST_MMN,   // m^2 * N
    ST_BAND,  // m^2 * N * S
    ST_CN0,   // count * N
    ST_D0,
    ST_SQ0,
    ST_CN1,   // prev_one * N
    ST_D1,
    ST_SQ1,
    ST_CN2,   // prev_two * N
    ST_D2,
    ST_SQ2,
    ST_CHK,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

/* sv/btd_regs.sv */
// btd_regs: APB-style configuration register file.
// Depends on btd_pkg for the register map and the cfg_t struct.
`default_nettype none

module btd_regs (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [btd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [btd_pkg::DATA_W-1:0] pwdata,
  output logic      [btd_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  output btd_pkg::cfg_t                 cfg
);

  btd_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = btd_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_rate       <= btd_pkg::MIN_RATE_RST;
      cfg.count_floor    <= btd_pkg::COUNT_FLOOR_RST;
      cfg.skip_length    <= btd_pkg::SKIP_LENGTH_RST;
      cfg.sigma_multiple <= btd_pkg::SIGMA_MULTIPLE_RST;
    end else if (wr_en) begin
      unique case (idx)
        btd_pkg::REG_MIN_RATE:       cfg.min_rate       <= pwdata[15:0];
        btd_pkg::REG_COUNT_FLOOR:    cfg.count_floor    <= pwdata[15:0];
        btd_pkg::REG_SKIP_LENGTH:    cfg.skip_length    <= pwdata[15:0];
        btd_pkg::REG_SIGMA_MULTIPLE: cfg.sigma_multiple <= pwdata[3:0];
        default:                     cfg.min_rate       <= cfg.min_rate;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      btd_pkg::REG_MIN_RATE:       prdata = {16'd0, cfg.min_rate};
      btd_pkg::REG_COUNT_FLOOR:    prdata = {16'd0, cfg.count_floor};
      btd_pkg::REG_SKIP_LENGTH:    prdata = {16'd0, cfg.skip_length};
      btd_pkg::REG_SIGMA_MULTIPLE: prdata = {28'd0, cfg.sigma_multiple};
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/btd_mul.sv */
// btd_mul: shared 24x24 multiplier with a registered product.
// Depends on btd_pkg for operand and product widths.
`default_nettype none

module btd_mul (
  input  wire logic                        clk,
  input  wire logic [btd_pkg::MUL_W-1:0]  a,
  input  wire logic [btd_pkg::MUL_W-1:0]  b,
  output logic      [btd_pkg::PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= btd_pkg::PROD_W'(a) * btd_pkg::PROD_W'(b);
  end

endmodule

`default_nettype wire

/* sv/beam_trip_detector.sv */
// beam_trip_detector: baseline sum, sequencer and trip decision around one multiplier.
// Baseline item: the sum is registered on acceptance, and FIN moves the result into
// the output register once it is free; the next request waits for IDLE. Scan item:
// runs ten passes through the shared multiplier plus the difference and compare steps.
// A new request is taken while a finished result still waits in the output register.
// Reset (rst, synchronous, active high) clears the sum, history and counters, and
// returns the config registers to their defaults.
// Depends on btd_pkg, btd_regs and btd_mul.
`default_nettype none

module beam_trip_detector #(
  parameter int AVG_COUNT   = 200,
  parameter int BUFFER_SIZE = 65536
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [btd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [btd_pkg::DATA_W-1:0] pwdata,
  output logic      [btd_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                        in_valid,
  output logic                            in_ready,
  input  wire logic                        kind,
  input  wire logic [15:0]                count,
  input  wire logic                        first,
  output logic                            out_valid,
  input  wire logic                        out_ready,
  output logic      [1:0]                 event_res,
  output logic      [15:0]                sample_index,
  output logic      [15:0]                trip_number
);

  localparam logic [btd_pkg::AVG_W-1:0] AVG_N   = btd_pkg::AVG_W'(AVG_COUNT);
  localparam logic [16:0]               BUF_END = 17'(BUFFER_SIZE);

  btd_pkg::cfg_t   cfg;
  btd_pkg::state_t state, state_next;

  // state of the model
  logic [btd_pkg::SUM_W-1:0] baseline_sum;
  logic [15:0] prev_one, prev_two, buffer_position, skip_left, trips_in_buffer;

  // per-request work registers
  logic                        kind_r;
  logic [15:0]                 cur_count, pos_r;
  logic                        band_mode_r, out_now_r, in_one_r, in_two_r;
  logic [btd_pkg::BAND_W-1:0]  band_r;
  logic [btd_pkg::MUL_W-1:0]   d_r;

  logic [btd_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [btd_pkg::PROD_W-1:0]  prod;

  logic                        accept, out_load;
  logic [15:0]                 pos_in;
  logic [btd_pkg::SUM_W-1:0]   sum_base;
  logic [btd_pkg::SUM_W:0]     sum_wide;
  logic [btd_pkg::MUL_W-1:0]   cn, abs_diff;
  logic                        p_gt_band, p_lt_band;
  btd_pkg::ev_t                ev;
  logic [16:0]                 pos_inc;

  btd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  btd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) state <= btd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      btd_pkg::ST_IDLE: begin
        if (accept) state_next = kind ? btd_pkg::ST_MRN : btd_pkg::ST_FIN;
      end
      btd_pkg::ST_MRN:  state_next = btd_pkg::ST_MM;
      btd_pkg::ST_MM:   state_next = btd_pkg::ST_MMN;
      btd_pkg::ST_MMN:  state_next = btd_pkg::ST_BAND;
      btd_pkg::ST_BAND: state_next = btd_pkg::ST_CN0;
      btd_pkg::ST_CN0:  state_next = btd_pkg::ST_D0;
      btd_pkg::ST_D0:   state_next = btd_pkg::ST_SQ0;
      btd_pkg::ST_SQ0:  state_next = btd_pkg::ST_CN1;
      btd_pkg::ST_CN1:  state_next = btd_pkg::ST_D1;
      btd_pkg::ST_D1:   state_next = btd_pkg::ST_SQ1;
      btd_pkg::ST_SQ1:  state_next = btd_pkg::ST_CN2;
      btd_pkg::ST_CN2:  state_next = btd_pkg::ST_D2;
      btd_pkg::ST_D2:   state_next = btd_pkg::ST_SQ2;
      btd_pkg::ST_SQ2:  state_next = btd_pkg::ST_CHK;
      btd_pkg::ST_CHK:  state_next = btd_pkg::ST_FIN;
      btd_pkg::ST_FIN: begin
        if (out_load) state_next = btd_pkg::ST_IDLE;
      end
      default:          state_next = btd_pkg::ST_IDLE;
    endcase
  end

  // operand select for the shared multiplier; in_ready is set in IDLE
  always_comb begin
    in_ready = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      btd_pkg::ST_IDLE: in_ready = 1'b1;
      btd_pkg::ST_MRN: begin
        mul_a = btd_pkg::MUL_W'(cfg.min_rate);
        mul_b = btd_pkg::MUL_W'(AVG_N);
      end
      btd_pkg::ST_MM: begin
        mul_a = btd_pkg::MUL_W'(cfg.sigma_multiple);
        mul_b = btd_pkg::MUL_W'(cfg.sigma_multiple);
      end
      btd_pkg::ST_MMN: begin
        mul_a = btd_pkg::MUL_W'(prod[7:0]);
        mul_b = btd_pkg::MUL_W'(AVG_N);
      end
      btd_pkg::ST_BAND: begin
        mul_a = btd_pkg::MUL_W'(prod[15:0]);
        mul_b = baseline_sum;
      end
      btd_pkg::ST_CN0: begin
        mul_a = btd_pkg::MUL_W'(cur_count);
        mul_b = btd_pkg::MUL_W'(AVG_N);
      end
      btd_pkg::ST_CN1: begin
        mul_a = btd_pkg::MUL_W'(prev_one);
        mul_b = btd_pkg::MUL_W'(AVG_N);
      end
      btd_pkg::ST_CN2: begin
        mul_a = btd_pkg::MUL_W'(prev_two);
        mul_b = btd_pkg::MUL_W'(AVG_N);
      end
      btd_pkg::ST_SQ0, btd_pkg::ST_SQ1, btd_pkg::ST_SQ2: begin
        mul_a = d_r;
        mul_b = d_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------- datapath ----------------
  assign accept   = in_valid && in_ready;
  assign out_load = (state == btd_pkg::ST_FIN) && (!out_valid || out_ready);
  assign pos_in   = first ? 16'd0 : buffer_position;

  assign sum_base = first ? '0 : baseline_sum;
  assign sum_wide = {1'b0, sum_base} +
                    ((count > cfg.count_floor) ? (btd_pkg::SUM_W + 1)'(count) : '0);

  assign cn       = prod[btd_pkg::MUL_W-1:0];
  assign abs_diff = (cn >= baseline_sum) ? cn - baseline_sum : baseline_sum - cn;

  assign p_gt_band = prod > btd_pkg::PROD_W'(band_r);
  assign p_lt_band = prod < btd_pkg::PROD_W'(band_r);

  always_comb begin
    ev = btd_pkg::EV_NONE;
    priority if (skip_left != 16'd0) begin
      ev = btd_pkg::EV_NONE;
    end else if (band_mode_r) begin
      if (out_now_r && in_one_r && in_two_r) ev = btd_pkg::EV_BAND;
    end else if (cur_count > cfg.min_rate) begin
      ev = btd_pkg::EV_HIGH;
    end
  end

  assign pos_inc = {1'b0, pos_r} + 17'd1;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= kind;
      cur_count <= count;
      pos_r     <= pos_in;
    end
    unique case (state)
      btd_pkg::ST_MM:  band_mode_r <= baseline_sum > prod[btd_pkg::SUM_W-1:0];
      btd_pkg::ST_CN0: band_r      <= prod[btd_pkg::BAND_W-1:0];
      btd_pkg::ST_D0, btd_pkg::ST_D1, btd_pkg::ST_D2: d_r <= abs_diff;
      btd_pkg::ST_CN1: out_now_r   <= p_gt_band;
      btd_pkg::ST_CN2: in_one_r    <= p_lt_band;
      btd_pkg::ST_CHK: in_two_r    <= p_lt_band;
      default:         d_r         <= d_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_sum    <= '0;
      prev_one        <= '0;
      prev_two        <= '0;
      buffer_position <= '0;
      skip_left       <= '0;
      trips_in_buffer <= '0;
    end else if (accept) begin
      if (!kind) begin
        baseline_sum <= sum_wide[btd_pkg::SUM_W] ? '1 : sum_wide[btd_pkg::SUM_W-1:0];
      end else if (pos_in == 16'd0) begin
        // buffer start: trip count and skip cleared, history taken equal to this sample
        trips_in_buffer <= '0;
        skip_left       <= '0;
        prev_one        <= count;
        prev_two        <= count;
      end
    end else if (out_load && kind_r) begin
      if (skip_left != 16'd0)        skip_left <= skip_left - 16'd1;
      else if (ev == btd_pkg::EV_BAND) skip_left <= cfg.skip_length;
      if (ev != btd_pkg::EV_NONE && trips_in_buffer != 16'hFFFF) begin
        trips_in_buffer <= trips_in_buffer + 16'd1;
      end
      prev_two        <= prev_one;
      prev_one        <= cur_count;
      buffer_position <= (pos_inc >= BUF_END) ? 16'd0 : pos_inc[15:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      event_res    <= kind_r ? ev : btd_pkg::EV_NONE;
      sample_index <= kind_r ? pos_r : 16'd0;
      trip_number  <= kind_r ? trips_in_buffer : 16'd0;
    end
  end

  // ---------------- checks ----------------
  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == btd_pkg::ST_FIN && !out_valid) |=> out_valid)
    else $error("finished request not moved to output register");

  a_buffer_start: assert property (@(posedge clk) disable iff (rst)
    (accept && kind && first) |=> (trips_in_buffer == 16'd0 && skip_left == 16'd0))
    else $error("buffer start did not clear trip state");

  a_band_mode: assert property (@(posedge clk) disable iff (rst)
    (out_load && kind_r && ev == btd_pkg::EV_BAND) |-> (band_mode_r && skip_left == 16'd0))
    else $error("band trip outside band mode or during skip");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != btd_pkg::ST_IDLE && state != btd_pkg::ST_FIN) |=> !$past(accept))
    else $error("request accepted while sequencer busy");

endmodule

`default_nettype wire
